@@ rtl/core/asgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR segment parser package
// Request types, parser mode codes, result kinds and character constants
// shared by the parser RTL.
// ----------------------------------------------------------------------------
package asgr_pkg;

  // One input request: a byte of the terminal line and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_line;
  } in_t;

  // One result request.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  text_byte;
    logic [6:0]  segment_number;
    logic [11:0] start_column;
    logic [9:0]  char_count;
    logic [9:0]  byte_count;
    logic [4:0]  fore_color;
    logic [3:0]  back_color;
    logic        bold_on;
    logic        last;
  } out_t;

  // Result kinds.
  localparam logic [1:0] KIND_TEXT    = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Parser modes.
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_PARAM = 2'd2;
  localparam logic [1:0] MODE_FULL  = 2'd3;

  // Token phases held in the low two bits of the token flags.
  localparam logic [1:0] PH_EMPTY  = 2'd0;
  localparam logic [1:0] PH_BLANK  = 2'd1;
  localparam logic [1:0] PH_NUMBER = 2'd2;
  localparam logic [1:0] PH_ENDED  = 2'd3;

  // Characters.
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // UTF-8 continuation bytes have the form 10xxxxxx.
  localparam logic [7:0] UTF8_MASK = 8'hC0;
  localparam logic [7:0] UTF8_CONT = 8'h80;

  // SGR codes.
  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_BOLD      = 8'd1;
  localparam logic [7:0] SGR_FG_LO     = 8'd30;
  localparam logic [7:0] SGR_FG_HI     = 8'd37;
  localparam logic [7:0] SGR_FG_BR_LO  = 8'd90;
  localparam logic [7:0] SGR_FG_BR_HI  = 8'd97;
  localparam logic [7:0] SGR_BG_LO     = 8'd40;
  localparam logic [7:0] SGR_BG_HI     = 8'd47;

  localparam logic [11:0] COLUMN_MAX = 12'hFFF;
  localparam logic [7:0]  CODE_MAX   = 8'hFF;

endpackage

@@ rtl/core/ansi_sgr_segment_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR segment parser
// Byte-serial parser of SGR escape sequences in a terminal line, reporting
// echoed text bytes, closed segments and a per-line summary.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a line arrive on the in_ channel (valid/ready), one request per
//   byte, with end_of_line set on the final byte. Each byte causes zero to
//   four result requests on the out_ channel (valid/ready); the last one of
//   a byte carries last = 1. A byte that only moves the parser (ESC, the
//   bytes of a control sequence) causes no result at all.
//   Results pass through a four-slot burst buffer and an output register
//   and leave one per cycle while the receiver takes them.
//   Throughput: one byte per cycle as long as each byte gives at most one
//   result and the receiver does not stall; a byte with more results holds
//   the input until the single output register drains the burst buffer.
//   When the receiver stalls, the output register holds its request and the
//   parser still takes bytes while the burst buffer is empty; once a byte
//   puts results into it, in_ready stays low until the buffer drains.
//   Reset (synchronous, active low) returns the parser to text mode with
//   default attributes and empty counters, and drops all pending results.
// ----------------------------------------------------------------------------
module ansi_sgr_segment_parser #(
  parameter int SEGMENT_LIMIT = 64,
  parameter int SEGMENT_BYTES = 1024,
  parameter int PARAM_BUFFER  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  asgr_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output asgr_pkg::out_t   out_data
);

  import asgr_pkg::*;

  // Counter widths follow the parameters. The segment byte counter never
  // exceeds SEGMENT_BYTES-1, the segment total never exceeds SEGMENT_LIMIT
  // and the parameter length never exceeds PARAM_BUFFER-1.
  localparam int SBW = $clog2(SEGMENT_BYTES);
  localparam int STW = $clog2(SEGMENT_LIMIT + 1);
  localparam int PLW = $clog2(PARAM_BUFFER);

  localparam logic [SBW-1:0] SEG_BYTE_MAX = SBW'(SEGMENT_BYTES - 1);
  localparam logic [STW-1:0] SEG_LIMIT    = STW'(SEGMENT_LIMIT);
  localparam logic [PLW-1:0] PARAM_MAX    = PLW'(PARAM_BUFFER - 1);

  typedef struct packed {
    logic [4:0] fore;
    logic [3:0] back;
    logic       bold;
  } attr_t;

  // Token being read: flags hold the phase in [1:0] and the minus sign in [2].
  typedef struct packed {
    logic [2:0] flags;
    logic [7:0] value;
  } tok_t;

  // Apply one SGR code to the current attributes. Unknown codes are ignored.
  function automatic attr_t apply_code(attr_t a, logic [7:0] code);
    attr_t r;
    r = a;
    if (code == SGR_RESET) begin
      r = '0;
    end else if (code == SGR_BOLD) begin
      r.bold = 1'b1;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      r.fore = 5'(code - SGR_FG_LO + 8'd1);
    end else if (code >= SGR_FG_BR_LO && code <= SGR_FG_BR_HI) begin
      r.fore = 5'(code - SGR_FG_BR_LO + 8'd9);
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      r.back = 4'(code - SGR_BG_LO + 8'd1);
    end
    return r;
  endfunction

  // Close a token. An empty token does nothing; a negative nonzero value
  // has no effect either.
  function automatic attr_t end_token(tok_t t, attr_t a);
    attr_t r;
    r = a;
    if (t.flags[1:0] != PH_EMPTY && !(t.flags[2] && t.value != 8'd0)) begin
      r = apply_code(a, t.value);
    end
    return r;
  endfunction

  // Advance the token reader by one byte that is not a separator.
  function automatic tok_t token_byte(tok_t t, logic [7:0] c);
    tok_t        r;
    logic [1:0]  phase;
    logic        digit;
    logic [11:0] v;
    r     = t;
    phase = t.flags[1:0];
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    v     = 12'(t.value) * 12'd10 + 12'(c - CH_ZERO);
    if (phase == PH_EMPTY || phase == PH_BLANK) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        phase = PH_BLANK;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        phase = PH_NUMBER;
        if (c == CH_MINUS) begin
          r.flags[2] = 1'b1;
        end
      end else if (digit) begin
        phase   = PH_NUMBER;
        r.value = c - CH_ZERO;
      end else begin
        phase = PH_ENDED;
      end
    end else if (phase == PH_NUMBER) begin
      if (digit) begin
        r.value = (v > 12'd255) ? CODE_MAX : v[7:0];
      end else begin
        phase = PH_ENDED;
      end
    end
    r.flags[1:0] = phase;
    return r;
  endfunction

  function automatic out_t make_result(logic [1:0] kind, logic [7:0] tb, logic [6:0] sn,
                                       logic [11:0] col, logic [9:0] ch, logic [9:0] by,
                                       attr_t a);
    out_t r;
    r.kind           = kind;
    r.text_byte      = tb;
    r.segment_number = sn;
    r.start_column   = col;
    r.char_count     = ch;
    r.byte_count     = by;
    r.fore_color     = a.fore;
    r.back_color     = a.back;
    r.bold_on        = a.bold;
    r.last           = 1'b0;
    return r;
  endfunction

  // Running parser state.
  logic [1:0]     mode_r, mode_nxt;
  attr_t          attr_r, attr_nxt;
  tok_t           tok_r, tok_nxt;
  logic [PLW-1:0] plen_r, plen_nxt;
  logic [11:0]    col_r, col_nxt;
  logic [STW-1:0] seg_total_r, seg_total_nxt;
  logic [SBW-1:0] seg_bytes_r, seg_bytes_nxt;
  logic [SBW-1:0] seg_chars_r, seg_chars_nxt;

  // Results of the byte being accepted.
  out_t           res_nxt [4];
  logic [2:0]     res_cnt_nxt;

  // Burst buffer of results still to be sent, slot 0 first.
  out_t           burst_r [4];
  logic [2:0]     burst_cnt_r;

  out_t           out_data_r;
  logic           out_valid_r;

  logic           in_fire;
  logic           out_move;
  logic           burst_pop;

  // Decode flags for the byte.
  logic           open_csi;
  logic           store_esc;
  logic           text_path;
  logic [7:0]     c;
  logic           eol;
  logic [12:0]    col_sum;

  assign c   = in_data.data_byte;
  assign eol = in_data.end_of_line;

  // The output register moves when it is empty or its request is taken.
  assign out_move  = !out_valid_r || out_ready;
  assign burst_pop = (burst_cnt_r != 3'd0) && out_move;

  // A new byte is taken once the burst buffer is empty at the end of this cycle.
  assign in_ready = (burst_cnt_r == 3'd0) || (burst_cnt_r == 3'd1 && out_move);
  assign in_fire  = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mode_nxt      = mode_r;
    attr_nxt      = attr_r;
    tok_nxt       = tok_r;
    plen_nxt      = plen_r;
    col_nxt       = col_r;
    seg_total_nxt = seg_total_r;
    seg_bytes_nxt = seg_bytes_r;
    seg_chars_nxt = seg_chars_r;
    res_cnt_nxt   = 3'd0;
    col_sum       = '0;
    for (int i = 0; i < 4; i++) begin
      res_nxt[i] = '0;
    end
    open_csi  = 1'b0;
    store_esc = 1'b0;
    text_path = 1'b0;

    case (mode_r)
      MODE_ESC: begin
        if (c == CH_LBRACKET) begin
          open_csi = 1'b1;
        end else begin
          // A lone ESC becomes text, and this byte is handled afresh.
          store_esc = 1'b1;
          text_path = 1'b1;
        end
      end
      MODE_PARAM: begin
        if (c == CH_M) begin
          if (plen_r == '0) begin
            attr_nxt = '0;
          end else begin
            attr_nxt = end_token(tok_r, attr_r);
            tok_nxt  = '0;
          end
          mode_nxt = MODE_TEXT;
        end else begin
          plen_nxt = plen_r + 1'b1;
          if (c == CH_SEMI) begin
            attr_nxt = end_token(tok_r, attr_r);
            tok_nxt  = '0;
          end else begin
            tok_nxt = token_byte(tok_r, c);
          end
          // Full parameter buffer: apply what was read; a following 'm' is swallowed, any other byte is text.
          if (plen_nxt >= PARAM_MAX) begin
            attr_nxt = end_token(tok_nxt, attr_nxt);
            tok_nxt  = '0;
            mode_nxt = MODE_FULL;
          end
        end
      end
      MODE_FULL: begin
        if (c == CH_M) begin
          mode_nxt = MODE_TEXT;
        end else begin
          text_path = 1'b1;
        end
      end
      default: begin
        text_path = 1'b1;
      end
    endcase

    // Opening a control sequence closes the pending segment, if any, while the segment limit is not reached.
    if (open_csi) begin
      if (seg_bytes_nxt != '0 && seg_total_nxt < SEG_LIMIT) begin
        res_nxt[res_cnt_nxt[1:0]] = make_result(KIND_CLOSE, 8'd0, 7'(seg_total_nxt), col_nxt,
                                                10'(seg_chars_nxt), 10'(seg_bytes_nxt),
                                                attr_nxt);
        res_cnt_nxt   = res_cnt_nxt + 3'd1;
        col_sum       = 13'(col_nxt) + 13'(seg_chars_nxt);
        col_nxt       = (col_sum > 13'(COLUMN_MAX)) ? COLUMN_MAX : col_sum[11:0];
        seg_total_nxt = seg_total_nxt + 1'b1;
        seg_bytes_nxt = '0;
        seg_chars_nxt = '0;
      end
      plen_nxt = '0;
      tok_nxt  = '0;
      mode_nxt = MODE_PARAM;
    end

    if (store_esc) begin
      res_nxt[res_cnt_nxt[1:0]] = make_result(KIND_TEXT, CH_ESC, 7'd0, 12'd0, 10'd0, 10'd0,
                                              attr_nxt);
      res_cnt_nxt = res_cnt_nxt + 3'd1;
      if (seg_bytes_nxt < SEG_BYTE_MAX) begin
        seg_bytes_nxt = seg_bytes_nxt + 1'b1;
        seg_chars_nxt = seg_chars_nxt + 1'b1;
      end
    end

    if (text_path) begin
      mode_nxt = MODE_TEXT;
      if (c == CH_ESC && !eol) begin
        mode_nxt = MODE_ESC;
      end else begin
        res_nxt[res_cnt_nxt[1:0]] = make_result(KIND_TEXT, c, 7'd0, 12'd0, 10'd0, 10'd0,
                                                attr_nxt);
        res_cnt_nxt = res_cnt_nxt + 3'd1;
        // Bytes past the segment byte limit are echoed but not counted.
        if (seg_bytes_nxt < SEG_BYTE_MAX) begin
          seg_bytes_nxt = seg_bytes_nxt + 1'b1;
          if ((c & UTF8_MASK) != UTF8_CONT) begin
            seg_chars_nxt = seg_chars_nxt + 1'b1;
          end
        end
      end
    end

    if (eol) begin
      // An unterminated sequence is applied at the end of the line.
      if (mode_nxt == MODE_PARAM) begin
        if (plen_nxt == '0) begin
          attr_nxt = '0;
        end else begin
          attr_nxt = end_token(tok_nxt, attr_nxt);
        end
      end
      if (seg_bytes_nxt != '0 && seg_total_nxt < SEG_LIMIT) begin
        res_nxt[res_cnt_nxt[1:0]] = make_result(KIND_CLOSE, 8'd0, 7'(seg_total_nxt), col_nxt,
                                                10'(seg_chars_nxt), 10'(seg_bytes_nxt),
                                                attr_nxt);
        res_cnt_nxt   = res_cnt_nxt + 3'd1;
        col_sum       = 13'(col_nxt) + 13'(seg_chars_nxt);
        col_nxt       = (col_sum > 13'(COLUMN_MAX)) ? COLUMN_MAX : col_sum[11:0];
        seg_total_nxt = seg_total_nxt + 1'b1;
      end
      res_nxt[res_cnt_nxt[1:0]] = make_result(KIND_SUMMARY, 8'd0, 7'(seg_total_nxt), col_nxt,
                                              10'd0, 10'd0, '0);
      res_cnt_nxt = res_cnt_nxt + 3'd1;
      // Everything returns to its reset value for the next line.
      mode_nxt      = MODE_TEXT;
      attr_nxt      = '0;
      tok_nxt       = '0;
      plen_nxt      = '0;
      col_nxt       = '0;
      seg_total_nxt = '0;
      seg_bytes_nxt = '0;
      seg_chars_nxt = '0;
    end

    if (res_cnt_nxt != 3'd0) begin
      res_nxt[2'(res_cnt_nxt - 3'd1)].last = 1'b1;
    end
  end

  // Parser state advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TEXT;
      attr_r      <= '0;
      tok_r       <= '0;
      plen_r      <= '0;
      col_r       <= '0;
      seg_total_r <= '0;
      seg_bytes_r <= '0;
      seg_chars_r <= '0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      attr_r      <= attr_nxt;
      tok_r       <= tok_nxt;
      plen_r      <= plen_nxt;
      col_r       <= col_nxt;
      seg_total_r <= seg_total_nxt;
      seg_bytes_r <= seg_bytes_nxt;
      seg_chars_r <= seg_chars_nxt;
    end
  end

  // Burst buffer count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_cnt_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        burst_cnt_r <= res_cnt_nxt;
      end else if (burst_pop) begin
        burst_cnt_r <= burst_cnt_r - 3'd1;
      end
      if (out_move) begin
        out_valid_r <= (burst_cnt_r != 3'd0);
      end
    end
  end

  // Burst buffer and output payload. A new byte loads all four slots; a pop
  // shifts the remaining results toward slot 0.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) begin
        burst_r[i] <= res_nxt[i];
      end
    end else if (burst_pop) begin
      for (int i = 0; i < 3; i++) begin
        burst_r[i] <= burst_r[i+1];
      end
    end
    if (out_move) begin
      out_data_r <= burst_r[0];
    end
  end

`ifndef SYNTHESIS
  // The end of a line leaves the parser in its reset state.
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eol) |=> (mode_r == MODE_TEXT && seg_bytes_r == '0 &&
                          col_r == '0 && seg_total_r == '0))
    else $error("parser state not cleared after end of line");

  // A line summary always closes the results of its byte.
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_SUMMARY) |-> out_data.last)
    else $error("line summary without last flag");

  // Segment counters stay within their limits.
  a_seg_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_bytes_r <= SEG_BYTE_MAX && seg_chars_r <= seg_bytes_r &&
     seg_total_r <= SEG_LIMIT))
    else $error("segment counters out of range");

  // The burst buffer never holds more than one byte's worth of results.
  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_cnt_r <= 3'd4)
    else $error("burst buffer overfilled");
`endif

endmodule

@@ test/ansi_sgr_segment_parser_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR segment parser checker
// Follows every accepted byte with its own copy of the parser state, queues
// the text echoes, segment closes and line summaries it implies, and checks
// each result request against the oldest one still due.
// ----------------------------------------------------------------------------
module ansi_sgr_segment_parser_chk #(
  parameter int SEGMENT_LIMIT = 64,
  parameter int SEGMENT_BYTES = 1024,
  parameter int PARAM_BUFFER  = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  asgr_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  asgr_pkg::out_t out_data,
  output int             fail_count,
  output int             results_due
);
  import asgr_pkg::*;

  localparam logic [4:0] BRIGHT_BASE = 5'd9;
  localparam int         PRINT_CAP   = 100;

  // Parser state, cleared at reset and after every line end.
  logic [1:0]  mode;
  logic [4:0]  fore;
  logic [3:0]  back;
  logic        bold;
  logic [7:0]  code;
  logic [1:0]  phase;
  logic        minus;
  logic [5:0]  param_len;
  logic [11:0] column;
  logic [6:0]  seg_total;
  logic [9:0]  seg_bytes;
  logic [9:0]  seg_chars;

  out_t step_results[$];
  out_t parser_results[$];
  int   results_seen;

  function automatic void reset_attrs();
    fore = '0;
    back = '0;
    bold = 1'b0;
  endfunction

  function automatic void clear_token();
    phase = PH_EMPTY;
    minus = 1'b0;
    code  = '0;
  endfunction

  function automatic void clear_line();
    mode = MODE_TEXT;
    reset_attrs();
    clear_token();
    param_len = '0;
    column    = '0;
    seg_total = '0;
    seg_bytes = '0;
    seg_chars = '0;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [7:0] text, logic [6:0] seg,
                                     logic [11:0] col, logic [9:0] chars,
                                     logic [9:0] bytes, bit attrs);
    out_t r;
    r = '0;
    r.kind           = kind;
    r.text_byte      = text;
    r.segment_number = seg;
    r.start_column   = col;
    r.char_count     = chars;
    r.byte_count     = bytes;
    if (attrs) begin
      r.fore_color = fore;
      r.back_color = back;
      r.bold_on    = bold;
    end
    step_results.push_back(r);
  endfunction

  function automatic void apply_code(logic [7:0] c);
    if (c == SGR_RESET) reset_attrs();
    else if (c == SGR_BOLD) bold = 1'b1;
    else if (c >= SGR_FG_LO && c <= SGR_FG_HI) fore = 5'(c - SGR_FG_LO + 8'd1);
    else if (c >= SGR_FG_BR_LO && c <= SGR_FG_BR_HI) fore = 5'(c - SGR_FG_BR_LO) + BRIGHT_BASE;
    else if (c >= SGR_BG_LO && c <= SGR_BG_HI) back = 4'(c - SGR_BG_LO + 8'd1);
  endfunction

  // A token that saw anything at all is applied, unless it is a nonzero
  // negative number.
  function automatic void end_token();
    if (phase != PH_EMPTY && !(minus && code != 0)) apply_code(code);
    clear_token();
  endfunction

  function automatic void token_byte(logic [7:0] c);
    bit digit;
    int acc;
    digit = (c >= CH_ZERO && c <= CH_NINE);
    if (c == CH_SEMI) begin
      end_token();
    end else if (phase == PH_EMPTY || phase == PH_BLANK) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        phase = PH_BLANK;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        phase = PH_NUMBER;
        if (c == CH_MINUS) minus = 1'b1;
      end else if (digit) begin
        phase = PH_NUMBER;
        code  = c - CH_ZERO;
      end else begin
        phase = PH_ENDED;
      end
    end else if (phase == PH_NUMBER) begin
      if (digit) begin
        acc  = int'(code) * 10 + int'(c - CH_ZERO);
        code = (acc > CODE_MAX) ? CODE_MAX : acc[7:0];
      end else begin
        phase = PH_ENDED;
      end
    end
  endfunction

  function automatic void finish_params();
    if (param_len == 0) reset_attrs();
    else end_token();
  endfunction

  function automatic void store_text(logic [7:0] c);
    add_result(KIND_TEXT, c, '0, '0, '0, '0, 1'b1);
    if (seg_bytes < SEGMENT_BYTES - 1) begin
      seg_bytes++;
      if ((c & UTF8_MASK) != UTF8_CONT) seg_chars++;
    end
  endfunction

  function automatic void close_segment();
    int sum;
    if (seg_bytes != 0 && seg_total < SEGMENT_LIMIT) begin
      add_result(KIND_CLOSE, '0, seg_total, column, seg_chars, seg_bytes, 1'b1);
      sum       = int'(column) + int'(seg_chars);
      column    = (sum > COLUMN_MAX) ? COLUMN_MAX : sum[11:0];
      seg_total++;
      seg_bytes = '0;
      seg_chars = '0;
    end
  endfunction

  // An ESC is held back unless it ends the line.
  function automatic void plain_byte(logic [7:0] c, logic eol);
    mode = MODE_TEXT;
    if (c == CH_ESC && !eol) mode = MODE_ESC;
    else store_text(c);
  endfunction

  function automatic void parse_byte(in_t req);
    logic [7:0] c;
    logic       eol;
    out_t       r;
    c   = req.data_byte;
    eol = req.end_of_line;
    step_results.delete();
    case (mode)
      MODE_ESC: begin
        if (c == CH_LBRACKET) begin
          close_segment();
          param_len = '0;
          clear_token();
          mode = MODE_PARAM;
        end else begin
          store_text(CH_ESC);
          plain_byte(c, eol);
        end
      end
      MODE_PARAM: begin
        if (c == CH_M) begin
          finish_params();
          mode = MODE_TEXT;
        end else begin
          param_len++;
          token_byte(c);
          if (param_len >= PARAM_BUFFER - 1) begin
            finish_params();
            mode = MODE_FULL;
          end
        end
      end
      MODE_FULL: begin
        if (c == CH_M) mode = MODE_TEXT;
        else plain_byte(c, eol);
      end
      default: begin
        plain_byte(c, eol);
      end
    endcase
    if (eol) begin
      if (mode == MODE_PARAM) finish_params();
      close_segment();
      add_result(KIND_SUMMARY, '0, seg_total, column, '0, '0, 1'b0);
      clear_line();
    end
    if (step_results.size() > 0) begin
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i]) parser_results.push_back(step_results[i]);
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count < PRINT_CAP) $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [11:0] got, logic [11:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, should be %0h",
                                results_seen, name, got, want));
  endtask

  task automatic compare_result(out_t got, out_t want);
    check_field("kind", 12'(got.kind), 12'(want.kind));
    check_field("text_byte", 12'(got.text_byte), 12'(want.text_byte));
    check_field("segment_number", 12'(got.segment_number), 12'(want.segment_number));
    check_field("start_column", got.start_column, want.start_column);
    check_field("char_count", 12'(got.char_count), 12'(want.char_count));
    check_field("byte_count", 12'(got.byte_count), 12'(want.byte_count));
    check_field("fore_color", 12'(got.fore_color), 12'(want.fore_color));
    check_field("back_color", 12'(got.back_color), 12'(want.back_color));
    check_field("bold_on", 12'(got.bold_on), 12'(want.bold_on));
    check_field("last", 12'(got.last), 12'(want.last));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      clear_line();
      parser_results.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (parser_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing due: %h",
                                    results_seen, out_data));
        end else begin
          want = parser_results.pop_front();
          compare_result(out_data, want);
        end
        results_seen++;
      end
      if (in_valid && in_ready) parse_byte(in_data);
    end
    results_due = parser_results.size();
  end

endmodule

@@ test/ansi_sgr_segment_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ANSI SGR segment parser testbench
// Feeds terminal lines byte by byte: a short directed opening, a line that
// pushes the segment count past its limit, then random lines of text and
// SGR sequences under four idling patterns. A separate checker predicts
// and compares every result request.
// ----------------------------------------------------------------------------
module ansi_sgr_segment_parser_tb;
  import asgr_pkg::*;

  localparam int SEGMENT_LIMIT = 64;
  localparam int SEGMENT_BYTES = 1024;
  localparam int PARAM_BUFFER  = 64;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  // The whole run is around 450 bytes; even if every byte gave four results
  // with the receiver stalling most of the time it would stay within the limit.
  localparam int CYCLE_LIMIT  = 50000;
  // Room for the output register and up to four results per byte, plus margin.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 140;

  // Idling patterns: none, sender only, receiver only, both.
  localparam int IDLE_IN [4] = '{0, 57, 0, 22};
  localparam int STALL_OUT [4] = '{0, 0, 57, 22};

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int fail_count;
  int results_due;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int items_sent = 0;

  // Bytes of the line under construction; the last one carries end_of_line.
  logic [7:0] line_buf[$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  ansi_sgr_segment_parser #(
    .SEGMENT_LIMIT(SEGMENT_LIMIT),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .PARAM_BUFFER (PARAM_BUFFER)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ansi_sgr_segment_parser_chk #(
    .SEGMENT_LIMIT(SEGMENT_LIMIT),
    .SEGMENT_BYTES(SEGMENT_BYTES),
    .PARAM_BUFFER (PARAM_BUFFER)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  // The receiver decides each cycle, independently of out_valid, whether it
  // takes a result request. Changing at the falling edge keeps out_ready
  // stable around the rising edge where the handshake is sampled.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, results_due);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sends one byte request. It is entered at a falling edge and returns at
  // the falling edge after the request was accepted, so in_valid only gets
  // one assignment per edge and stays high across back-to-back requests.
  task automatic send_req(input logic [7:0] b, input logic eol);
    in_t req;
    req.data_byte   = b;
    req.end_of_line = eol;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_req(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_num(input int v);
    add_str($sformatf("%0d", v));
  endtask

  // A code the parser acts on: reset, bold, or one of the color ranges.
  function automatic int pick_sgr_code();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? int'(SGR_BOLD) : int'(SGR_RESET);
      1: return int'(SGR_FG_LO) + int'($urandom_range(0, 7));
      2: return int'(SGR_BG_LO) + int'($urandom_range(0, 7));
      default: return int'(SGR_FG_BR_LO) + int'($urandom_range(0, 7));
    endcase
  endfunction

  // One parameter token, mostly valid codes, with the odd forms mixed in:
  // unknown and oversized values, signs, leading blanks, empty and junk.
  task automatic add_token();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2, 3: begin
        add_num(pick_sgr_code());
      end
      4: begin
        add_num($urandom_range(0, 999));
      end
      5: begin
        line_buf.push_back(CH_MINUS);
        add_num($urandom_range(0, 40));
      end
      6: begin
        line_buf.push_back(CH_PLUS);
        add_num(pick_sgr_code());
      end
      7: begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, 5);
          line_buf.push_back(k == 0 ? CH_SPACE : 8'(int'(CH_TAB) + k - 1));
        end
        add_num(pick_sgr_code());
        if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
      end
      8: begin
        // An empty token adds nothing.
      end
      default: begin
        // A letter before or inside the number; 'a' to 'l' never ends the sequence.
        if ($urandom_range(0, 1)) line_buf.push_back(8'(8'h61 + $urandom_range(0, 11)));
        add_num(pick_sgr_code());
        line_buf.push_back(8'(8'h61 + $urandom_range(0, 11)));
        if ($urandom_range(0, 1)) add_num($urandom_range(0, 9));
      end
    endcase
  endtask

  // A well-formed SGR sequence. Zero tokens gives the empty sequence.
  task automatic add_sequence();
    int ntok;
    ntok = $urandom_range(0, 4);
    line_buf.push_back(CH_ESC);
    line_buf.push_back(CH_LBRACKET);
    for (int i = 0; i < ntok; i++) begin
      if (i != 0) line_buf.push_back(CH_SEMI);
      add_token();
    end
    if ($urandom_range(0, 7) == 0) line_buf.push_back(CH_SEMI);
    line_buf.push_back(CH_M);
  endtask

  // One random line: mostly text runs and well-formed sequences, some lone
  // or broken escapes, and now and then a parameter list long enough to
  // fill the buffer.
  task automatic build_random_line();
    int nchunk;
    int r;
    int mark;
    int target;
    nchunk = $urandom_range(1, 6);
    repeat (nchunk) begin
      r = $urandom_range(0, 19);
      if (r < 8) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            5: line_buf.push_back(8'(UTF8_CONT + $urandom_range(0, 63)));
            6: line_buf.push_back(8'(UTF8_MASK + $urandom_range(0, 63)));
            7: line_buf.push_back(8'($urandom_range(0, 255)));
            8: line_buf.push_back(CH_ESC);
            default: line_buf.push_back(8'h00);
          endcase
        end
      end else if (r < 16) begin
        add_sequence();
      end else if (r == 16) begin
        // Lone ESC followed by any byte.
        line_buf.push_back(CH_ESC);
        line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r == 17) begin
        // A sequence without its final 'm': later bytes become parameters.
        line_buf.push_back(CH_ESC);
        line_buf.push_back(CH_LBRACKET);
        add_token();
      end else begin
        // Long parameter list around the buffer limit, then 'm' or text.
        line_buf.push_back(CH_ESC);
        line_buf.push_back(CH_LBRACKET);
        mark   = line_buf.size();
        target = $urandom_range(PARAM_BUFFER - 6, PARAM_BUFFER + 6);
        while (line_buf.size() - mark < target) begin
          add_token();
          line_buf.push_back(CH_SEMI);
        end
        if ($urandom_range(0, 1)) line_buf.push_back(CH_M);
        line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
  endtask

  initial begin
    int start;
    int stage;

    // Reset is held at the start, and only then.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, no idling. The first line has a zero byte, a lone
    // ESC, a sequence setting bold, a bright foreground and a background, a
    // high byte, a UTF-8 continuation byte and an ESC as the final byte.
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_ESC);
    add_str("q");
    line_buf.push_back(CH_ESC);
    add_str("[1;97;47m");
    line_buf.push_back(8'hFF);
    line_buf.push_back(UTF8_CONT);
    line_buf.push_back(CH_ESC);
    send_line();
    // The second line has an empty sequence and one with only a separator.
    line_buf.push_back(CH_ESC);
    add_str("[ma");
    line_buf.push_back(CH_ESC);
    add_str("[;mb");
    send_line();

    // Limits, with light idling on both sides: more one-byte segments in one
    // line than the parser reports closes for.
    idle_pct  = IDLE_IN[3];
    stall_pct = STALL_OUT[3];
    repeat (SEGMENT_LIMIT + 2) begin
      line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      line_buf.push_back(CH_ESC);
      add_str("[m");
    end
    add_str("z");
    send_line();

    // Random lines, stepping through the four idling patterns.
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      stage     = (items_sent - start) * 4 / RANDOM_ITEMS;
      idle_pct  = IDLE_IN[stage];
      stall_pct = STALL_OUT[stage];
      build_random_line();
      send_line();
    end

    // All requests are in; wait for the last results, then a little longer
    // to catch anything extra the parser might still send.
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/asgr_pkg.sv
rtl/core/ansi_sgr_segment_parser.sv
test/ansi_sgr_segment_parser_chk.sv
test/ansi_sgr_segment_parser_tb.sv
